>>> hw/rtl/format_string_expander_top_defines.svh
// Assertion macros for the format string expander top level.
// Included by format_string_expander_top, which carries the concurrent checks; needs no package.
`ifndef FORMAT_STRING_EXPANDER_TOP_DEFINES_SVH
`define FORMAT_STRING_EXPANDER_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define FSE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define FSE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/fse_pkg.sv
// Types and constants for the format string expander.
// Used by fse_ctrl, fse_dp and format_string_expander_top; no dependencies.
`default_nettype none

package fse_pkg;

    localparam int          MAX_DIGITS  = 10;
    localparam int          CNT_W       = $clog2(MAX_DIGITS + 1);
    localparam logic [7:0]  CH_PERCENT  = 8'h25;
    localparam logic [7:0]  CH_C        = 8'h63;
    localparam logic [7:0]  CH_D        = 8'h64;
    localparam logic [7:0]  CH_MINUS    = 8'h2D;
    localparam logic [7:0]  CH_ZERO     = 8'd48;
    localparam logic [31:0] RECIP_10    = 32'hCCCC_CCCD;
    localparam int          RECIP_SHIFT = 35;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_CONV,
        ST_SIGN,
        ST_EMIT
    } t_state;

    typedef enum logic [2:0] {
        OSEL_CHAR,
        OSEL_ARG,
        OSEL_PERCENT,
        OSEL_MINUS,
        OSEL_DIGIT
    } t_out_sel;

    typedef struct packed {
        logic     ld_in;
        logic     pend_upd;
        logic     ld_conv;
        logic     conv_step;
        logic     pop;
        logic     out_load;
        logic     out_last;
        t_out_sel out_sel;
    } t_dp_cmd;

    typedef struct packed {
        logic pending;
        logic is_pct;
        logic is_c;
        logic is_d;
        logic fmt_end;
        logic neg;
        logic conv_done;
        logic last_digit;
        logic out_free;
    } t_dp_sts;

endpackage

`default_nettype wire

>>> hw/rtl/fse_dp.sv
// Datapath: request holding registers, pending flag, divide-by-ten digit
// unit, digit stack and output register. Depends on fse_pkg.
`default_nettype none

module fse_dp (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [7:0]       i_fmt_char,
    input  logic signed [31:0] i_arg_value,
    input  logic             i_fmt_end,
    input  logic             i_out_stall,
    input  fse_pkg::t_dp_cmd i_cmd,
    output fse_pkg::t_dp_sts o_sts,
    output logic             o_out_valid,
    output logic [7:0]       o_out_byte,
    output logic             o_run_last
);
    import fse_pkg::*;

    logic [7:0]       r_ch;
    logic [31:0]      r_arg;
    logic             r_end;
    logic             r_pending;
    logic [31:0]      r_mag;
    logic             r_neg;
    logic [CNT_W-1:0] r_cnt;
    logic [3:0]       r_digits [MAX_DIGITS];
    logic             r_ov;
    logic [7:0]       r_ob;
    logic             r_last;

    logic [63:0]      w_prod;
    logic [31:0]      w_q;
    logic [3:0]       w_q10;
    logic [3:0]       w_rem;
    logic             w_arg_neg;
    logic [31:0]      w_abs;
    logic [7:0]       w_out_byte;
    logic             w_out_free;

    assign w_prod    = 64'(r_mag) * 64'(RECIP_10);
    assign w_q       = 32'(w_prod[63:RECIP_SHIFT]);
    assign w_q10     = 4'({w_q[0], 3'b000}) + 4'({w_q[2:0], 1'b0});
    assign w_rem     = r_mag[3:0] - w_q10;
    assign w_arg_neg = r_arg[31];
    assign w_abs     = w_arg_neg ? (32'd0 - r_arg) : r_arg;
    assign w_out_free = !r_ov || !i_out_stall;

    always_comb begin
        case (i_cmd.out_sel)
            OSEL_CHAR:    w_out_byte = r_ch;
            OSEL_ARG:     w_out_byte = r_arg[7:0];
            OSEL_PERCENT: w_out_byte = CH_PERCENT;
            OSEL_MINUS:   w_out_byte = CH_MINUS;
            OSEL_DIGIT:   w_out_byte = CH_ZERO + {4'd0, r_digits[0]};
            default:      w_out_byte = r_ch;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= 1'b0;
            r_ov      <= 1'b0;
        end else begin
            if (i_cmd.pend_upd) begin
                r_pending <= !r_pending && (r_ch == CH_PERCENT) && !r_end;
            end
            if (i_cmd.out_load) begin
                r_ov <= 1'b1;
            end else if (!i_out_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_in) begin
            r_ch  <= i_fmt_char;
            r_arg <= i_arg_value;
            r_end <= i_fmt_end;
        end
        if (i_cmd.out_load) begin
            r_ob   <= w_out_byte;
            r_last <= i_cmd.out_last;
        end
        if (i_cmd.ld_conv) begin
            r_mag <= w_abs;
            r_neg <= w_arg_neg;
            r_cnt <= '0;
        end else if (i_cmd.conv_step) begin
            r_mag <= w_q;
            r_cnt <= r_cnt + CNT_W'(1);
        end else if (i_cmd.pop) begin
            r_cnt <= r_cnt - CNT_W'(1);
        end
        if (i_cmd.conv_step) begin
            r_digits[0] <= w_rem;
            for (int i = 1; i < MAX_DIGITS; i++) begin
                r_digits[i] <= r_digits[i-1];
            end
        end else if (i_cmd.pop) begin
            for (int i = 0; i < MAX_DIGITS - 1; i++) begin
                r_digits[i] <= r_digits[i+1];
            end
            r_digits[MAX_DIGITS-1] <= '0;
        end
    end

    always_comb begin
        o_sts.pending    = r_pending;
        o_sts.is_pct     = (r_ch == CH_PERCENT);
        o_sts.is_c       = (r_ch == CH_C);
        o_sts.is_d       = (r_ch == CH_D);
        o_sts.fmt_end    = r_end;
        o_sts.neg        = r_neg;
        o_sts.conv_done  = (w_q == 32'd0) || (r_cnt == CNT_W'(MAX_DIGITS - 1));
        o_sts.last_digit = (r_cnt == CNT_W'(1));
        o_sts.out_free   = w_out_free;
    end

    assign o_out_valid = r_ov;
    assign o_out_byte  = r_ob;
    assign o_run_last  = r_last;

endmodule

`default_nettype wire

>>> hw/rtl/fse_ctrl.sv
// Controller state machine: takes a request, decodes it, sequences the
// digit conversion and the output bytes. Depends on fse_pkg.
`default_nettype none

module fse_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  fse_pkg::t_dp_sts i_sts,
    output logic             o_in_stall,
    output fse_pkg::t_dp_cmd o_cmd
);
    import fse_pkg::*;

    t_state   r_state;
    t_state   n_state;
    logic     w_emit;
    logic     w_start_conv;
    t_out_sel w_sel;

    // decode of the held request
    always_comb begin
        w_emit       = 1'b0;
        w_start_conv = 1'b0;
        w_sel        = OSEL_CHAR;
        if (i_sts.pending) begin
            if (i_sts.is_pct) begin
                w_emit = 1'b1;
                w_sel  = OSEL_PERCENT;
            end else if (i_sts.is_c) begin
                w_emit = 1'b1;
                w_sel  = OSEL_ARG;
            end else if (i_sts.is_d) begin
                w_start_conv = 1'b1;
            end
        end else if (!i_sts.is_pct) begin
            w_emit = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_EXEC;
            end
            ST_EXEC: begin
                if (w_start_conv) begin
                    n_state = ST_CONV;
                end else if (!w_emit || i_sts.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            ST_CONV: begin
                if (i_sts.conv_done) n_state = i_sts.neg ? ST_SIGN : ST_EMIT;
            end
            ST_SIGN: begin
                if (i_sts.out_free) n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (i_sts.out_free && i_sts.last_digit) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_stall = (r_state != ST_IDLE);
        case (r_state)
            ST_IDLE: begin
                o_cmd.ld_in = i_in_valid;
            end
            ST_EXEC: begin
                o_cmd.out_sel = w_sel;
                if (w_start_conv) begin
                    o_cmd.ld_conv  = 1'b1;
                    o_cmd.pend_upd = 1'b1;
                end else if (!w_emit) begin
                    o_cmd.pend_upd = 1'b1;
                end else if (i_sts.out_free) begin
                    o_cmd.pend_upd = 1'b1;
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_last = 1'b1;
                end
            end
            ST_CONV: begin
                o_cmd.conv_step = 1'b1;
            end
            ST_SIGN: begin
                o_cmd.out_sel  = OSEL_MINUS;
                o_cmd.out_load = i_sts.out_free;
            end
            ST_EMIT: begin
                o_cmd.out_sel  = OSEL_DIGIT;
                o_cmd.out_load = i_sts.out_free;
                o_cmd.out_last = i_sts.last_digit;
                o_cmd.pop      = i_sts.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> hw/rtl/format_string_expander_top.sv
// Top level of the format string expander: controller plus datapath.
// Depends on fse_pkg, fse_ctrl, fse_dp and the assertion macro header.
//
//   channel  | valid         | stall         | payload
//   ---------+---------------+---------------+----------------------------------
//   input    | i_in_valid    | o_in_stall    | i_fmt_char, i_arg_value, i_fmt_end
//   output   | o_out_valid   | i_out_stall   | o_out_byte, o_run_last
//
// An ordinary byte, a lone % (which only sets the pending flag) and a %% or %c conversion
// pass through the idle and exec states. %d adds divide-by-ten steps (one multiply by
// reciprocal per digit), an optional minus sign byte and one output byte per digit.
// One request is in work at a time; the next is taken while the output register holds a byte.
// Reset is synchronous, active low; it clears the state, the pending flag and the output valid flag.
// A stalled output holds the byte and pauses the sequence.
`default_nettype none

module format_string_expander_top (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [7:0]        i_fmt_char,
    input  logic signed [31:0] i_arg_value,
    input  logic              i_fmt_end,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [7:0]        o_out_byte,
    output logic              o_run_last
);
    import fse_pkg::*;

    `include "format_string_expander_top_defines.svh"

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    fse_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (w_sts),
        .o_in_stall (o_in_stall),
        .o_cmd      (w_cmd)
    );

    fse_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fmt_char  (i_fmt_char),
        .i_arg_value (i_arg_value),
        .i_fmt_end   (i_fmt_end),
        .i_out_stall (i_out_stall),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_out_valid (o_out_valid),
        .o_out_byte  (o_out_byte),
        .o_run_last  (o_run_last)
    );

    `FSE_ASSERT_NOW(a_load_when_free, i_clk, i_rst_n, w_cmd.out_load, w_sts.out_free,
        "output overwritten")
    `FSE_ASSERT_NEXT(a_busy_after_take, i_clk, i_rst_n, i_in_valid && !o_in_stall,
        o_in_stall, "not busy after request")
    `FSE_ASSERT_NEXT(a_idle_after_last, i_clk, i_rst_n, w_cmd.out_load && w_cmd.out_last,
        !o_in_stall, "not idle after last byte")
    `FSE_ASSERT_NEXT(a_end_clears_pend, i_clk, i_rst_n, w_cmd.pend_upd && w_sts.fmt_end,
        !w_sts.pending, "pending kept past end")

endmodule

`default_nettype wire
